FILE: design/kcdp_pkg.sv
package kcdp_pkg;

  localparam int unsigned NUM_KEYS  = 8;
  localparam int unsigned NUM_SLOTS = NUM_KEYS + 3;
  localparam int unsigned KEY_W     = 8;
  localparam int unsigned SEL_W     = 4;
  localparam int unsigned MASK_W    = 11;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OUT_W     = 32;

  localparam logic [SEL_W-1:0] SLOT_START    = SEL_W'(0);
  localparam logic [SEL_W-1:0] SLOT_MON_DOWN = SEL_W'(NUM_KEYS);
  localparam logic [SEL_W-1:0] SLOT_MON_UP   = SEL_W'(NUM_KEYS + 1);
  localparam logic [SEL_W-1:0] SLOT_UP_DOWN  = SEL_W'(NUM_KEYS + 2);
  localparam logic [SEL_W-1:0] SLOT_NONE     = SEL_W'(NUM_KEYS + 3);

  localparam int unsigned KEY_START = 0;
  localparam int unsigned KEY_MON   = 1;
  localparam int unsigned KEY_UP    = 2;
  localparam int unsigned KEY_DOWN  = 3;

  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t CNT_MAX          = {CNT_W{1'b1}};
  localparam cnt_t DEB_ON_RESET     = CNT_W'(5);
  localparam cnt_t DEB_OFF_RESET    = CNT_W'(5);
  localparam cnt_t PULSE_RESET      = CNT_W'(10);
  localparam cnt_t STUCK_TMO_RESET  = CNT_W'(6000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEB_ON    = 3'd0,
    CFG_DEB_OFF   = 3'd1,
    CFG_PULSE     = 3'd2,
    CFG_STUCK_TMO = 3'd3,
    CFG_CLICK_EN  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    cnt_t deb_on;
    cnt_t deb_off;
    cnt_t pulse;
    cnt_t stuck_tmo;
    logic click_en;
  } cfg_t;

  typedef struct packed {
    logic level;
    logic pulse;
    logic start;
  } slot_status_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    cnt_t r;
    r = (v == CNT_MAX) ? CNT_MAX : v + cnt_t'(1);
    return r;
  endfunction

endpackage

FILE: design/kcdp_slot.sv
module kcdp_slot import kcdp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic         select_i,
  input  logic         released_i,
  input  cfg_t         cfg_i,
  output slot_status_t status_o
);

  cnt_t det_q, det_d, rel_q, rel_d, pcnt_q, pcnt_d;
  logic level_q, level_d, pulse_q, pulse_d, auth_q, auth_d;

  cnt_t det_inc, det_a, rel_a, pcnt_a;
  logic hit, auth_a, start, level_a, pulse_a;

  always_comb begin
    det_inc = sat_inc(det_q);
    hit     = select_i && (det_inc >= cfg_i.deb_on);
    auth_a  = auth_q | released_i;
    start   = hit && auth_a && !pulse_q;
    det_a   = hit ? cfg_i.deb_on : (select_i ? det_inc : det_q);
    level_a = level_q | hit;
    rel_a   = hit ? '0 : rel_q;
    pulse_a = pulse_q | start;
    pcnt_a  = start ? '0 : pcnt_q;

    det_d   = det_a;
    rel_d   = rel_a;
    level_d = level_a;
    pcnt_d  = pcnt_a;
    pulse_d = pulse_a;
    auth_d  = auth_a;
    if (level_a) begin
      rel_d = sat_inc(rel_a);
      if (rel_d >= cfg_i.deb_off) begin
        level_d = 1'b0;
        det_d   = '0;
      end
    end
    if (pulse_a) begin
      pcnt_d = sat_inc(pcnt_a);
      if (pcnt_d >= cfg_i.pulse) begin
        pulse_d = 1'b0;
        auth_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_q   <= '0;
      rel_q   <= '0;
      pcnt_q  <= '0;
      level_q <= 1'b0;
      pulse_q <= 1'b0;
      auth_q  <= 1'b0;
    end else if (step_i) begin
      det_q   <= det_d;
      rel_q   <= rel_d;
      pcnt_q  <= pcnt_d;
      level_q <= level_d;
      pulse_q <= pulse_d;
      auth_q  <= auth_d;
    end
  end

  assign status_o.level = level_d;
  assign status_o.pulse = pulse_d;
  assign status_o.start = start;

endmodule

FILE: design/keypad_chord_debounce_pulse_core.sv
// Keypad debouncer with chord detection. Each input transaction on the s_axis
// channel carries one tick's raw key mask; each tick yields exactly one output
// transaction on the m_axis channel with the selected slot, the debounced
// level and pulse masks, the click flag and the stuck-key anomaly flag.
// The tick is held in an input register, all eleven slots and the stuck
// countdown are updated in parallel by one level of logic, and the result is
// captured in an output register. A tick passes through both registers before
// it appears on m_axis; throughput is one tick per cycle while the receiver
// does not stall. The cfg port writes the timing registers and click enable;
// the user must use it only while no tick is in flight, which the block does
// not enforce. Reset clears slot counters and flags, loads the stuck countdown
// and the timing registers with their defaults and leaves both channels empty.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more tick; after that s_axis_tready drops
// until the output transaction completes. No tick is lost or repeated.
module keypad_chord_debounce_pulse_core import kcdp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // key_mask[7:0]
  input  logic [KEY_W-1:0]     s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // selected_code[3:0], level_mask[14:4], pulse_mask[25:15], click[26],
  // stuck_anomaly[27], zero padding[31:28]
  output logic [OUT_W-1:0]     m_axis_tdata
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deb_on    <= DEB_ON_RESET;
      cfg_q.deb_off   <= DEB_OFF_RESET;
      cfg_q.pulse     <= PULSE_RESET;
      cfg_q.stuck_tmo <= STUCK_TMO_RESET;
      cfg_q.click_en  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_DEB_ON:    cfg_q.deb_on    <= cfg_wdata_i;
        CFG_DEB_OFF:   cfg_q.deb_off   <= cfg_wdata_i;
        CFG_PULSE:     cfg_q.pulse     <= cfg_wdata_i;
        CFG_STUCK_TMO: cfg_q.stuck_tmo <= cfg_wdata_i;
        CFG_CLICK_EN:  cfg_q.click_en  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  logic             in_valid_q;
  logic [KEY_W-1:0] in_mask_q;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q, out_data_d;
  logic             step;

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mask_q <= s_axis_tdata;
    end
    if (step) begin
      out_data_q <= out_data_d;
    end
  end

  logic                 k_ss, k_mon, k_up, k_dn;
  logic [SEL_W-1:0]     sel;
  logic [NUM_SLOTS-1:0] released;

  always_comb begin
    k_ss  = in_mask_q[KEY_START];
    k_mon = in_mask_q[KEY_MON];
    k_up  = in_mask_q[KEY_UP];
    k_dn  = in_mask_q[KEY_DOWN];
    sel   = SLOT_NONE;
    if (k_ss) begin
      sel = SLOT_START;
    end else if (k_mon && k_dn) begin
      sel = SLOT_MON_DOWN;
    end else if (k_mon && k_up) begin
      sel = SLOT_MON_UP;
    end else if (k_up && k_dn) begin
      sel = SLOT_UP_DOWN;
    end else begin
      for (int i = NUM_KEYS - 1; i >= 1; i--) begin
        if (in_mask_q[i]) begin
          sel = SEL_W'(i);
        end
      end
    end
    for (int i = 0; i < NUM_KEYS; i++) begin
      released[i] = !in_mask_q[i];
    end
    released[NUM_KEYS]     = !k_mon || !k_dn;
    released[NUM_KEYS + 1] = !k_mon || !k_up;
    released[NUM_KEYS + 2] = !k_up || !k_dn;
  end

  slot_status_t         status [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] level_mask, pulse_mask, start_mask;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
    kcdp_slot u_slot (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (step),
      .select_i   (sel == SEL_W'(g)),
      .released_i (released[g]),
      .cfg_i      (cfg_q),
      .status_o   (status[g])
    );
    assign level_mask[g] = status[g].level;
    assign pulse_mask[g] = status[g].pulse;
    assign start_mask[g] = status[g].start;
  end

  logic [SEL_W-1:0] prev_sel_q, stuck_sel_q, stuck_sel_d;
  cnt_t             stuck_cd_q, stuck_cd_d;
  logic             anomaly, click;

  always_comb begin
    stuck_cd_d  = (stuck_cd_q != '0) ? stuck_cd_q - cnt_t'(1) : '0;
    stuck_sel_d = stuck_sel_q;
    if ((sel == SLOT_NONE) || ((sel != prev_sel_q) && (stuck_sel_q == SLOT_NONE))) begin
      stuck_sel_d = SLOT_NONE;
      stuck_cd_d  = cfg_q.stuck_tmo;
    end
    anomaly = (stuck_cd_d == '0);
    if (anomaly) begin
      stuck_sel_d = sel;
    end
    click      = cfg_q.click_en && (|start_mask);
    out_data_d = {4'b0000, anomaly, click, MASK_W'(pulse_mask), MASK_W'(level_mask), sel};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sel_q  <= SLOT_NONE;
      stuck_sel_q <= SLOT_NONE;
      stuck_cd_q  <= STUCK_TMO_RESET;
    end else if (step) begin
      prev_sel_q  <= sel;
      stuck_sel_q <= stuck_sel_d;
      stuck_cd_q  <= stuck_cd_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the output could advance");

  a_click_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[26]) |-> (m_axis_tdata[3:0] != SLOT_NONE))
    else $error("click reported without a selected slot");

  a_sel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3:0] <= SLOT_NONE))
    else $error("selected code out of range");

  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> m_axis_tvalid)
    else $error("processed tick did not reach the output register");
`endif

endmodule
